[rtl/cdt_pkg.sv]
// Shared constants, codes and controller/datapath handshake types.
package cdt_pkg;

    localparam int unsigned DEF_ROUTE_ENTRIES   = 32;
    localparam int unsigned DEF_PENDING_ENTRIES = 8;
    localparam int unsigned DEF_COMPONENT_PORTS = 16;
    localparam int unsigned DEF_CALLER_PORTS    = 4;

    localparam logic [31:0] RESERVED_CODE = 32'hFFFF_FFFF;

    localparam logic [15:0] COMP_LINKS_RESET   = 16'hFFFF;
    localparam logic [3:0]  CALLER_LINKS_RESET = 4'hF;

    // configuration register indexes
    localparam logic CFG_COMP_LINKS   = 1'b0;
    localparam logic CFG_CALLER_LINKS = 1'b1;

    // item opcodes
    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_STATUS   = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_NONE       = 3'd0;
    localparam logic [2:0] KIND_FORWARD    = 3'd1;
    localparam logic [2:0] KIND_STATUS     = 3'd2;
    localparam logic [2:0] KIND_REGISTERED = 3'd3;
    localparam logic [2:0] KIND_CLEARED    = 3'd4;
    localparam logic [2:0] KIND_FAULT      = 3'd5;

    // response codes
    localparam logic [2:0] RESP_OK         = 3'd0;
    localparam logic [2:0] RESP_INVALID    = 3'd1;
    localparam logic [2:0] RESP_VALIDATION = 3'd2;
    localparam logic [2:0] RESP_EXECUTION  = 3'd4;

    // fault codes
    localparam logic [2:0] FAULT_NONE       = 3'd0;
    localparam logic [2:0] FAULT_RESERVED   = 3'd1;
    localparam logic [2:0] FAULT_TABLE_FULL = 3'd2;
    localparam logic [2:0] FAULT_OTHER_PORT = 3'd3;
    localparam logic [2:0] FAULT_MISMATCH   = 3'd4;

    typedef struct packed {
        logic load;
        logic route_run;
        logic pend_run;
        logic commit;
    } cdt_cmd_t;

    typedef struct packed {
        logic need_route;
        logic route_done;
        logic need_pend;
        logic pend_done;
        logic out_full;
    } cdt_stat_t;

endpackage

[rtl/cdt_ctrl.sv]
// Sequencing controller: accept, route scan, pending scan, commit.
module cdt_ctrl
    import cdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  cdt_stat_t stat,
    output cdt_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUTE,
        S_PEND,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_ROUTE;
            end
            S_ROUTE:
            begin
                if (!stat.need_route || stat.route_done)
                    state_next = S_PEND;
            end
            S_PEND:
            begin
                if (!stat.need_pend || stat.pend_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!stat.out_full)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign cmd.load       = (state_reg == S_IDLE) && in_valid;
    assign cmd.route_run  = (state_reg == S_ROUTE) && stat.need_route;
    assign cmd.pend_run   = (state_reg == S_PEND) && stat.need_pend;
    assign cmd.commit     = (state_reg == S_COMMIT) && !stat.out_full;

endmodule

[rtl/cdt_datapath.sv]
// Route table, pending tracker, scan units and result register.
module cdt_datapath
    import cdt_pkg::*;
#(
    parameter int unsigned ROUTE_ENTRIES   = DEF_ROUTE_ENTRIES,
    parameter int unsigned PENDING_ENTRIES = DEF_PENDING_ENTRIES,
    parameter int unsigned COMPONENT_PORTS = DEF_COMPONENT_PORTS,
    parameter int unsigned CALLER_PORTS    = DEF_CALLER_PORTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cdt_cmd_t    cmd,
    output cdt_stat_t   stat,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  opcode,
    input  logic [3:0]  port,
    input  logic [31:0] command_code,
    input  logic [31:0] sequence_tag,
    input  logic [31:0] caller_context,
    input  logic [2:0]  response_code,
    input  logic        malformed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [3:0]  target_port,
    output logic [31:0] result_code,
    output logic [31:0] tag_or_context,
    output logic [2:0]  status_response,
    output logic [2:0]  fault_code
);

    localparam int unsigned RIW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int unsigned RCW = $clog2(ROUTE_ENTRIES + 1);
    localparam int unsigned PIW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int unsigned PCW = $clog2(PENDING_ENTRIES + 1);
    localparam int unsigned CW  = (CALLER_PORTS > 1) ? $clog2(CALLER_PORTS) : 1;

    // configuration
    logic [15:0] comp_links_reg;
    logic [3:0]  caller_links_reg;

    // latched item
    logic [1:0]  op_reg;
    logic [3:0]  port_reg;
    logic [31:0] code_reg;
    logic [31:0] tag_reg;
    logic [31:0] ctx_reg;
    logic [2:0]  resp_reg;
    logic        bad_reg;

    // route table
    logic [ROUTE_ENTRIES-1:0] route_valid_reg;
    logic [35:0]              route_mem [ROUTE_ENTRIES];
    logic [35:0]              route_rd_reg;
    logic [RCW-1:0]           ridx_reg;
    logic                     rpipe_reg;
    logic [RIW-1:0]           rpipe_idx_reg;
    logic                     rpipe_valid_reg;
    logic                     r_free_found_reg;
    logic [RIW-1:0]           r_free_idx_reg;
    logic                     r_same_reg;
    logic                     r_conf_reg;
    logic                     r_hit_reg;
    logic [3:0]               r_hit_port_reg;

    // pending tracker
    logic [PENDING_ENTRIES-1:0] pend_valid_reg;
    logic [31:0]                pend_code_reg [PENDING_ENTRIES];
    logic [CW-1:0]              pend_caller_reg [PENDING_ENTRIES];
    logic [31:0]                pend_tag_reg [PENDING_ENTRIES];
    logic [31:0]                pend_ctx_reg [PENDING_ENTRIES];
    logic [PCW-1:0]             pidx_reg;
    logic                       p_free_found_reg;
    logic [PIW-1:0]             p_free_idx_reg;
    logic                       p_match_reg;
    logic [PIW-1:0]             p_match_idx_reg;
    logic [31:0]                next_tag_reg;

    // result register
    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [3:0]  tport_reg;
    logic [31:0] rcode_reg;
    logic [31:0] toc_reg;
    logic [2:0]  sresp_reg;
    logic [2:0]  fault_reg;

    logic           reserved;
    logic           caller_ok;
    logic           comp_ok;
    logic           route_ok;
    logic           r_issue;
    logic           p_step;
    logic [PIW-1:0] pe;
    logic [3:0]     mcaller;
    logic           mcaller_ok;

    // commit decisions
    logic [2:0]  k_kind;
    logic [3:0]  k_port;
    logic [31:0] k_code;
    logic [31:0] k_toc;
    logic [2:0]  k_resp;
    logic [2:0]  k_fault;
    logic        k_route_wr;
    logic        k_pend_wr;
    logic        k_pend_free;
    logic        k_clear;
    logic        k_tag_inc;

    assign reserved  = (code_reg == RESERVED_CODE);
    assign caller_ok = ({1'b0, port_reg} < 5'(CALLER_PORTS)) && (port_reg < 4'd4)
                       && caller_links_reg[port_reg[1:0]];
    assign comp_ok   = ({3'b0, r_hit_port_reg} < 7'(COMPONENT_PORTS))
                       && comp_links_reg[r_hit_port_reg];
    assign route_ok  = r_hit_reg && comp_ok;
    assign r_issue   = cmd.route_run && (ridx_reg < RCW'(ROUTE_ENTRIES));
    assign p_step    = cmd.pend_run && (pidx_reg < PCW'(PENDING_ENTRIES));
    assign pe        = pidx_reg[PIW-1:0];
    assign mcaller   = 4'(pend_caller_reg[p_match_idx_reg]);
    assign mcaller_ok = ({1'b0, mcaller} < 5'(CALLER_PORTS)) && (mcaller < 4'd4)
                        && caller_links_reg[mcaller[1:0]];

    assign stat.need_route = ((op_reg == OP_REGISTER) && !reserved)
                             || ((op_reg == OP_DISPATCH) && !bad_reg);
    assign stat.route_done = (ridx_reg == RCW'(ROUTE_ENTRIES)) && !rpipe_reg;
    assign stat.need_pend  = ((op_reg == OP_STATUS) && !reserved)
                             || ((op_reg == OP_DISPATCH) && !bad_reg && route_ok && caller_ok);
    assign stat.pend_done  = (pidx_reg == PCW'(PENDING_ENTRIES));
    assign stat.out_full   = out_valid_reg && !out_ready;

    always_comb
    begin
        k_kind      = KIND_NONE;
        k_port      = 4'd0;
        k_code      = 32'd0;
        k_toc       = 32'd0;
        k_resp      = RESP_OK;
        k_fault     = FAULT_NONE;
        k_route_wr  = 1'b0;
        k_pend_wr   = 1'b0;
        k_pend_free = 1'b0;
        k_clear     = 1'b0;
        k_tag_inc   = 1'b0;
        case (op_reg)
            OP_REGISTER:
            begin
                k_port = port_reg;
                k_code = code_reg;
                if (reserved)
                begin
                    k_kind  = KIND_FAULT;
                    k_fault = FAULT_RESERVED;
                end
                else if (r_conf_reg)
                begin
                    k_kind  = KIND_FAULT;
                    k_fault = FAULT_OTHER_PORT;
                end
                else if (r_same_reg)
                    k_kind = KIND_REGISTERED;
                else if (!r_free_found_reg)
                begin
                    k_kind  = KIND_FAULT;
                    k_fault = FAULT_TABLE_FULL;
                end
                else
                begin
                    k_kind     = KIND_REGISTERED;
                    k_route_wr = 1'b1;
                end
            end
            OP_DISPATCH:
            begin
                if (bad_reg)
                begin
                    if (caller_ok)
                    begin
                        k_kind = KIND_STATUS;
                        k_port = port_reg;
                        k_code = code_reg;
                        k_toc  = ctx_reg;
                        k_resp = RESP_VALIDATION;
                    end
                end
                else if (route_ok)
                begin
                    if (caller_ok && !p_free_found_reg)
                    begin
                        k_kind = KIND_STATUS;
                        k_port = port_reg;
                        k_code = code_reg;
                        k_toc  = ctx_reg;
                        k_resp = RESP_EXECUTION;
                    end
                    else
                    begin
                        k_pend_wr = caller_ok;
                        k_kind    = KIND_FORWARD;
                        k_port    = r_hit_port_reg;
                        k_code    = code_reg;
                        k_toc     = next_tag_reg;
                        k_tag_inc = 1'b1;
                    end
                end
                else
                begin
                    k_tag_inc = 1'b1;
                    if (caller_ok)
                    begin
                        k_kind = KIND_STATUS;
                        k_port = port_reg;
                        k_code = code_reg;
                        k_toc  = ctx_reg;
                        k_resp = RESP_INVALID;
                    end
                end
            end
            OP_STATUS:
            begin
                if (reserved)
                begin
                    k_kind  = KIND_FAULT;
                    k_port  = port_reg;
                    k_code  = code_reg;
                    k_fault = FAULT_RESERVED;
                end
                else if (p_match_reg)
                begin
                    if (pend_code_reg[p_match_idx_reg] != code_reg)
                    begin
                        k_kind  = KIND_FAULT;
                        k_port  = port_reg;
                        k_code  = code_reg;
                        k_fault = FAULT_MISMATCH;
                    end
                    else
                    begin
                        k_pend_free = 1'b1;
                        if (mcaller_ok)
                        begin
                            k_kind = KIND_STATUS;
                            k_port = mcaller;
                            k_code = code_reg;
                            k_toc  = pend_ctx_reg[p_match_idx_reg];
                            k_resp = resp_reg;
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                k_kind  = KIND_CLEARED;
                k_code  = code_reg;
                k_toc   = tag_reg;
                k_clear = 1'b1;
            end
            default:
            begin
                k_kind = KIND_NONE;
            end
        endcase
    end

    // item latch, route memory, pending payload and result fields (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            port_reg <= port;
            code_reg <= command_code;
            tag_reg  <= sequence_tag;
            ctx_reg  <= caller_context;
            resp_reg <= response_code;
            bad_reg  <= malformed;
        end
        if (r_issue)
            route_rd_reg <= route_mem[ridx_reg[RIW-1:0]];
        if (cmd.commit && k_route_wr)
            route_mem[r_free_idx_reg] <= {code_reg, port_reg};
        if (cmd.commit && k_pend_wr)
        begin
            pend_code_reg[p_free_idx_reg]   <= code_reg;
            pend_caller_reg[p_free_idx_reg] <= port_reg[CW-1:0];
            pend_tag_reg[p_free_idx_reg]    <= next_tag_reg;
            pend_ctx_reg[p_free_idx_reg]    <= ctx_reg;
        end
        if (cmd.commit)
        begin
            kind_reg  <= k_kind;
            tport_reg <= k_port;
            rcode_reg <= k_code;
            toc_reg   <= k_toc;
            sresp_reg <= k_resp;
            fault_reg <= k_fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_links_reg   <= COMP_LINKS_RESET;
            caller_links_reg <= CALLER_LINKS_RESET;
            route_valid_reg  <= '0;
            pend_valid_reg   <= '0;
            next_tag_reg     <= 32'd0;
            out_valid_reg    <= 1'b0;
            ridx_reg         <= '0;
            rpipe_reg        <= 1'b0;
            rpipe_idx_reg    <= '0;
            rpipe_valid_reg  <= 1'b0;
            r_free_found_reg <= 1'b0;
            r_free_idx_reg   <= '0;
            r_same_reg       <= 1'b0;
            r_conf_reg       <= 1'b0;
            r_hit_reg        <= 1'b0;
            r_hit_port_reg   <= 4'd0;
            pidx_reg         <= '0;
            p_free_found_reg <= 1'b0;
            p_free_idx_reg   <= '0;
            p_match_reg      <= 1'b0;
            p_match_idx_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_COMP_LINKS)
                    comp_links_reg <= cfg_data;
                else
                    caller_links_reg <= cfg_data[3:0];
            end

            if (cmd.load)
            begin
                ridx_reg         <= '0;
                rpipe_reg        <= 1'b0;
                r_free_found_reg <= 1'b0;
                r_same_reg       <= 1'b0;
                r_conf_reg       <= 1'b0;
                r_hit_reg        <= 1'b0;
                pidx_reg         <= '0;
                p_free_found_reg <= 1'b0;
                p_match_reg      <= 1'b0;
            end
            else
            begin
                // route scan: issue one read a cycle, compare the registered read data
                if (cmd.route_run)
                begin
                    rpipe_reg <= r_issue;
                    if (r_issue)
                    begin
                        ridx_reg        <= ridx_reg + 1'b1;
                        rpipe_idx_reg   <= ridx_reg[RIW-1:0];
                        rpipe_valid_reg <= route_valid_reg[ridx_reg[RIW-1:0]];
                    end
                    if (rpipe_reg)
                    begin
                        if (!rpipe_valid_reg)
                        begin
                            if (!r_free_found_reg)
                            begin
                                r_free_found_reg <= 1'b1;
                                r_free_idx_reg   <= rpipe_idx_reg;
                            end
                        end
                        else if (route_rd_reg[35:4] == code_reg)
                        begin
                            r_hit_reg      <= 1'b1;
                            r_hit_port_reg <= route_rd_reg[3:0];
                            if (route_rd_reg[3:0] != port_reg)
                                r_conf_reg <= 1'b1;
                            else
                                r_same_reg <= 1'b1;
                        end
                    end
                end

                // pending scan: one entry a cycle
                if (p_step)
                begin
                    pidx_reg <= pidx_reg + 1'b1;
                    if (!pend_valid_reg[pe] && !p_free_found_reg)
                    begin
                        p_free_found_reg <= 1'b1;
                        p_free_idx_reg   <= pe;
                    end
                    if (pend_valid_reg[pe] && (pend_tag_reg[pe] == tag_reg) && !p_match_reg)
                    begin
                        p_match_reg     <= 1'b1;
                        p_match_idx_reg <= pe;
                    end
                end
            end

            if (cmd.commit)
            begin
                if (k_route_wr)
                    route_valid_reg[r_free_idx_reg] <= 1'b1;
                if (k_clear)
                    pend_valid_reg <= '0;
                else if (k_pend_wr)
                    pend_valid_reg[p_free_idx_reg] <= 1'b1;
                else if (k_pend_free)
                    pend_valid_reg[p_match_idx_reg] <= 1'b0;
                if (k_tag_inc)
                    next_tag_reg <= next_tag_reg + 32'd1;
            end

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign target_port     = tport_reg;
    assign result_code     = rcode_reg;
    assign tag_or_context  = toc_reg;
    assign status_response = sresp_reg;
    assign fault_code      = fault_reg;

endmodule

[rtl/command_dispatch_tracker_unit.sv]
// Top level of the command dispatch tracker: controller plus datapath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, opcode..malformed      | item in
//  out     | out_valid/out_ready, result_kind..fault   | item out
//  cfg     | cfg_we, cfg_index, cfg_data               | write only
//
// One item at a time. A register item with a non-reserved code or a well-formed
// dispatch scans the route table one entry per cycle through the table's
// registered read port, then compares the last entry and sees the scan done;
// a tracked dispatch or a status item with a non-reserved code then scans the
// pending table one entry per cycle. An item steps through the accept, route
// scan, pending scan and commit states in order, passing a scan it does not
// need; a clear needs neither scan. Reset clears valid bits and the sequence
// counter and sets every link bit at once; no clearing pass. The result register
// lets the next item be accepted while a result waits; commit stalls on a
// full one.
module command_dispatch_tracker_unit
    import cdt_pkg::*;
#(
    parameter int unsigned ROUTE_ENTRIES   = DEF_ROUTE_ENTRIES,
    parameter int unsigned PENDING_ENTRIES = DEF_PENDING_ENTRIES,
    parameter int unsigned COMPONENT_PORTS = DEF_COMPONENT_PORTS,
    parameter int unsigned CALLER_PORTS    = DEF_CALLER_PORTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [3:0]  port,
    input  logic [31:0] command_code,
    input  logic [31:0] sequence_tag,
    input  logic [31:0] caller_context,
    input  logic [2:0]  response_code,
    input  logic        malformed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [3:0]  target_port,
    output logic [31:0] result_code,
    output logic [31:0] tag_or_context,
    output logic [2:0]  status_response,
    output logic [2:0]  fault_code
);

    cdt_cmd_t  cmd;
    cdt_stat_t stat;

    // sequencer: steps each item through its scans, then commits the result
    cdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // tables, scan accumulators, link registers and the result register
    cdt_datapath #(
        .ROUTE_ENTRIES   (ROUTE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .COMPONENT_PORTS (COMPONENT_PORTS),
        .CALLER_PORTS    (CALLER_PORTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .port            (port),
        .command_code    (command_code),
        .sequence_tag    (sequence_tag),
        .caller_context  (caller_context),
        .response_code   (response_code),
        .malformed       (malformed),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .target_port     (target_port),
        .result_code     (result_code),
        .tag_or_context  (tag_or_context),
        .status_response (status_response),
        .fault_code      (fault_code)
    );

endmodule

[tb/sv/tb.sv]
// Testbench for command_dispatch_tracker_unit: random and directed items checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdt_pkg::*;

    // one input item as driven on the in channel
    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  port;
        logic [31:0] command_code;
        logic [31:0] sequence_tag;
        logic [31:0] caller_context;
        logic [2:0]  response_code;
        logic        malformed;
    } cmd_item_t;

    // one result item as seen on the out channel
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  target_port;
        logic [31:0] result_code;
        logic [31:0] tag_or_context;
        logic [2:0]  status_response;
        logic [2:0]  fault_code;
    } route_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [3:0]  port = '0;
    logic [31:0] command_code = '0;
    logic [31:0] sequence_tag = '0;
    logic [31:0] caller_context = '0;
    logic [2:0]  response_code = '0;
    logic        malformed = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  result_kind;
    logic [3:0]  target_port;
    logic [31:0] result_code;
    logic [31:0] tag_or_context;
    logic [2:0]  status_response;
    logic [2:0]  fault_code;

    command_dispatch_tracker_unit DUT (.*);

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the route table, pending table,
    // sequence counter and link masks.
    // ------------------------------------------------------------------
    logic [15:0] comp_links;
    logic [3:0]  caller_links;
    logic        rt_valid [32];
    logic [31:0] rt_code [32];
    logic [3:0]  rt_port [32];
    logic        pd_valid [8];
    logic [31:0] pd_code [8];
    logic [1:0]  pd_caller [8];
    logic [31:0] pd_tag [8];
    logic [31:0] pd_ctx [8];
    logic [31:0] tag_counter;

    cmd_item_t     pending_items[$];   // items waiting for the driver
    route_result_t expected_results[$];
    cmd_item_t     drv_item;
    int            errors = 0;
    int            accepted_items = 0;
    int            checked_results = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic [31:0]   known_codes[$];      // codes handed to register items

    // handshake seen at the last rising edge
    logic in_ready_seen = 1'b0;

    // rough guess at the counter so status tags often land on pending entries
    logic [31:0] tag_counter_hint = 0;

    function automatic route_result_t mk(logic [2:0] k, logic [3:0] p, logic [31:0] c,
                                         logic [31:0] t, logic [2:0] r, logic [2:0] f);
        route_result_t res;
        res.result_kind = k;
        res.target_port = p;
        res.result_code = c;
        res.tag_or_context = t;
        res.status_response = r;
        res.fault_code = f;
        return res;
    endfunction

    // Work out the result of one accepted item and update the predictor.
    function automatic route_result_t predict_route(cmd_item_t it);
        route_result_t res;
        int free_slot;
        int hit;
        int slot;
        logic same;
        logic linked;
        res = mk(KIND_NONE, 0, 0, 0, RESP_OK, FAULT_NONE);
        case (it.opcode)
            OP_REGISTER: begin
                if (it.command_code == RESERVED_CODE)
                    return mk(KIND_FAULT, it.port, it.command_code, 0, 0, FAULT_RESERVED);
                free_slot = -1;
                same = 1'b0;
                for (int i = 0; i < 32; i++) begin
                    if (!rt_valid[i]) begin
                        if (free_slot < 0) free_slot = i;
                    end
                    else if (rt_code[i] == it.command_code) begin
                        if (rt_port[i] != it.port)
                            return mk(KIND_FAULT, it.port, it.command_code, 0, 0,
                                      FAULT_OTHER_PORT);
                        same = 1'b1;
                    end
                end
                if (!same) begin
                    if (free_slot < 0)
                        return mk(KIND_FAULT, it.port, it.command_code, 0, 0,
                                  FAULT_TABLE_FULL);
                    rt_valid[free_slot] = 1'b1;
                    rt_code[free_slot] = it.command_code;
                    rt_port[free_slot] = it.port;
                end
                res = mk(KIND_REGISTERED, it.port, it.command_code, 0, 0, FAULT_NONE);
            end
            OP_DISPATCH: begin
                linked = (it.port < 4) && caller_links[it.port[1:0]];
                if (it.malformed) begin
                    if (linked)
                        res = mk(KIND_STATUS, it.port, it.command_code, it.caller_context,
                                 RESP_VALIDATION, FAULT_NONE);
                    return res;
                end
                hit = -1;
                if (it.command_code != RESERVED_CODE)
                    for (int i = 0; i < 32; i++)
                        if (rt_valid[i] && rt_code[i] == it.command_code) hit = i;
                if (hit >= 0 && comp_links[rt_port[hit]]) begin
                    if (linked) begin
                        slot = -1;
                        for (int i = 0; i < 8; i++)
                            if (!pd_valid[i] && slot < 0) slot = i;
                        if (slot < 0)
                            return mk(KIND_STATUS, it.port, it.command_code,
                                      it.caller_context, RESP_EXECUTION, FAULT_NONE);
                        pd_valid[slot] = 1'b1;
                        pd_code[slot] = it.command_code;
                        pd_caller[slot] = it.port[1:0];
                        pd_tag[slot] = tag_counter;
                        pd_ctx[slot] = it.caller_context;
                    end
                    res = mk(KIND_FORWARD, rt_port[hit], it.command_code, tag_counter, 0,
                             FAULT_NONE);
                end
                else if (linked)
                    res = mk(KIND_STATUS, it.port, it.command_code, it.caller_context,
                             RESP_INVALID, FAULT_NONE);
                tag_counter = tag_counter + 1;
            end
            OP_STATUS: begin
                if (it.command_code == RESERVED_CODE)
                    return mk(KIND_FAULT, it.port, it.command_code, 0, 0, FAULT_RESERVED);
                for (int i = 0; i < 8; i++)
                    if (pd_valid[i] && pd_tag[i] == it.sequence_tag) begin
                        if (pd_code[i] != it.command_code)
                            return mk(KIND_FAULT, it.port, it.command_code, 0, 0,
                                      FAULT_MISMATCH);
                        pd_valid[i] = 1'b0;
                        if (caller_links[pd_caller[i]])
                            res = mk(KIND_STATUS, {2'b00, pd_caller[i]}, it.command_code,
                                     pd_ctx[i], it.response_code, FAULT_NONE);
                        return res;
                    end
            end
            default: begin
                for (int i = 0; i < 8; i++) pd_valid[i] = 1'b0;
                res = mk(KIND_CLEARED, 0, it.command_code, it.sequence_tag, RESP_OK,
                         FAULT_NONE);
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: hands out queued items at the falling edge, with random gaps.
    // Valid stays up with a steady payload until the handshake.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_ready_seen) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    {opcode, port, command_code, sequence_tag, caller_context,
                     response_code, malformed} <= drv_item;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted item, checks each accepted result.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        route_result_t got;
        route_result_t exp_r;
        in_ready_seen <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            expected_results.push_back(predict_route({opcode, port, command_code,
                sequence_tag, caller_context, response_code, malformed}));
            accepted_items++;
        end
        if (rst_n && out_valid && out_ready) begin
            got = mk(result_kind, target_port, result_code, tag_or_context,
                     status_response, fault_code);
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d", got.result_kind);
                errors++;
            end
            else begin
                exp_r = expected_results.pop_front();
                checked_results++;
                if (got.result_kind !== exp_r.result_kind) begin
                    $error("result_kind exp %0d got %0d", exp_r.result_kind, got.result_kind);
                    errors++;
                end
                if (got.target_port !== exp_r.target_port) begin
                    $error("target_port exp %0d got %0d", exp_r.target_port, got.target_port);
                    errors++;
                end
                if (got.result_code !== exp_r.result_code) begin
                    $error("result_code exp %h got %h", exp_r.result_code, got.result_code);
                    errors++;
                end
                if (got.tag_or_context !== exp_r.tag_or_context) begin
                    $error("tag_or_context exp %h got %h", exp_r.tag_or_context,
                           got.tag_or_context);
                    errors++;
                end
                if (got.status_response !== exp_r.status_response) begin
                    $error("status_response exp %0d got %0d", exp_r.status_response,
                           got.status_response);
                    errors++;
                end
                if (got.fault_code !== exp_r.fault_code) begin
                    $error("fault_code exp %0d got %0d", exp_r.fault_code, got.fault_code);
                    errors++;
                end
            end
        end
    end

    function automatic cmd_item_t make_item(logic [1:0] op, logic [3:0] p, logic [31:0] c,
                                            logic [31:0] t, logic [31:0] x, logic [2:0] r,
                                            logic m);
        cmd_item_t it;
        it = {op, p, c, t, x, r, m};
        return it;
    endfunction

    // Random code: mostly from the known pool so dispatches hit the table.
    function automatic logic [31:0] pick_code();
        int sel;
        sel = $urandom_range(99);
        if (known_codes.size() > 0 && sel < 75)
            return known_codes[$urandom_range(known_codes.size() - 1)];
        if (sel < 80) return RESERVED_CODE;
        return $urandom();
    endfunction

    // Fill the queue with a random mix weighted toward dispatch/status flows.
    task automatic queue_random(int n);
        int sel;
        logic [31:0] c;
        logic [31:0] t;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            c = pick_code();
            t = tag_counter_hint + $urandom_range(12) - 6;
            if (sel < 18) begin
                if ($urandom_range(3) != 0 && known_codes.size() < 40) begin
                    c = $urandom();
                    known_codes.push_back(c);
                end
                pending_items.push_back(make_item(OP_REGISTER, 4'($urandom_range(15)), c,
                                        $urandom(), $urandom(), 3'($urandom_range(7)),
                                        1'($urandom_range(1))));
            end
            else if (sel < 60) begin
                pending_items.push_back(make_item(OP_DISPATCH, 4'($urandom_range(15)), c,
                                        $urandom(), $urandom(), 3'($urandom_range(7)),
                                        ($urandom_range(9) == 0)));
                tag_counter_hint++;
            end
            else if (sel < 96) begin
                if ($urandom_range(9) == 0) t = $urandom();
                pending_items.push_back(make_item(OP_STATUS, 4'($urandom_range(15)), c, t,
                                        $urandom(), 3'($urandom_range(7)),
                                        1'($urandom_range(1))));
            end
            else
                pending_items.push_back(make_item(OP_CLEAR, 4'($urandom_range(15)),
                                        $urandom(), $urandom(), $urandom(),
                                        3'($urandom_range(7)), 1'($urandom_range(1))));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);   // an item with no result may still be in flight
    endtask

    // Write one link register while idle, mirrored into the predictor.
    task automatic write_links(logic idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_COMP_LINKS) comp_links = val;
        else caller_links = val[3:0];
    endtask

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        queue_random(n);
        wait_drained();
    endtask

    initial begin
        comp_links = COMP_LINKS_RESET;
        caller_links = CALLER_LINKS_RESET;
        tag_counter = 0;
        for (int i = 0; i < 32; i++) rt_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++) pd_valid[i] = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every opcode and the listed corner cases.
        known_codes.push_back(32'h0);
        known_codes.push_back(32'h1234_5678);
        pending_items.push_back(make_item(OP_REGISTER, 0, 32'h0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_REGISTER, 15, 32'h1234_5678, '1, '1, 7, 1));
        pending_items.push_back(make_item(OP_REGISTER, 15, 32'h1234_5678, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_REGISTER, 3, 32'h1234_5678, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_REGISTER, 3, RESERVED_CODE, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_DISPATCH, 0, 32'h0, 0, '1, 0, 0));
        pending_items.push_back(make_item(OP_DISPATCH, 3, 32'h1234_5678, 0, 32'h5a5a, 0, 0));
        pending_items.push_back(make_item(OP_DISPATCH, 9, 32'h1234_5678, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_DISPATCH, 1, 32'hdead_beef, 0, 1, 0, 0));
        pending_items.push_back(make_item(OP_DISPATCH, 2, RESERVED_CODE, 0, 2, 0, 0));
        pending_items.push_back(make_item(OP_DISPATCH, 2, 32'h0, 0, 3, 0, 1));
        pending_items.push_back(make_item(OP_STATUS, 0, 32'h0, 0, 0, 7, 0));
        pending_items.push_back(make_item(OP_STATUS, 15, 32'h0, 1, 0, 5, 0));
        pending_items.push_back(make_item(OP_STATUS, 15, 32'h1234_5678, 1, 0, 6, 0));
        pending_items.push_back(make_item(OP_STATUS, 1, 32'h0, 32'h77, 0, 0, 0));
        pending_items.push_back(make_item(OP_STATUS, 1, RESERVED_CODE, 0, 0, 0, 0));
        for (int i = 0; i < 9; i++)   // fills the pending table, then overflows it
            pending_items.push_back(make_item(OP_DISPATCH, 4'(i % 4), 32'h0, 0, 32'(i),
                                              0, 0));
        pending_items.push_back(make_item(OP_CLEAR, 7, '1, '1, '1, 7, 1));
        tag_counter_hint = 14;
        wait_drained();

        // table full: register 34 fresh codes
        for (int i = 0; i < 34; i++)
            pending_items.push_back(make_item(OP_REGISTER, 4'(i % 16), 32'h8000_0000 + i,
                                              0, 0, 0, 0));
        wait_drained();

        run_phase(150, 0, 0);
        write_links(CFG_COMP_LINKS, 16'h0000);
        write_links(CFG_CALLER_LINKS, 16'h0000);
        run_phase(80, 63, 0);
        write_links(CFG_COMP_LINKS, 16'hA5C3);
        write_links(CFG_CALLER_LINKS, 16'h0005);
        run_phase(150, 0, 63);
        write_links(CFG_COMP_LINKS, 16'hFFFF);
        write_links(CFG_CALLER_LINKS, 16'h000F);
        run_phase(150, 26, 26);
        write_links(CFG_CALLER_LINKS, 16'h000A);
        run_phase(100, 0, 0);

        $display("Covered %0d items and %0d results over four idle/stall mixes",
                 accepted_items, checked_results);
        $display("and link masks from none to all, with route and pending tables filled.");
        if (errors == 0)
            $display("command_dispatch_tracker_unit test passed");
        else
            $display("command_dispatch_tracker_unit test failed");
        $finish;
    end

    // generous bound for ~700 items under heavy stalls
    initial begin
        #20ms;
        $display("command_dispatch_tracker_unit test failed");
        $finish;
    end

    // the predictor mirrors the sequence counter; keep hint roughly aligned
    always @(posedge clk) if (tag_counter > tag_counter_hint) tag_counter_hint <= tag_counter;

endmodule

[command_dispatch_tracker_unit.f]
rtl/cdt_pkg.sv
rtl/cdt_ctrl.sv
rtl/cdt_datapath.sv
rtl/command_dispatch_tracker_unit.sv
tb/sv/tb.sv
